// File: sv/bdcc_pkg.sv
package bdcc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 8'd1;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_DATA_W-1:0] HOLD_MS_RESET       = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_MS_RESET = 16'd500;

  // Stream widths
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef struct packed {
    logic   pressed;
    event_t evt;
  } result_t;

endpackage

// File: sv/bdcc_core.sv
module bdcc_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic                                 pin_level,
  input  logic [TIME_BITS-1:0]                 now,
  input  logic [bdcc_pkg::CFG_DATA_W-1:0]      hold_ms,
  input  logic [bdcc_pkg::CFG_DATA_W-1:0]      long_press_ms,
  output bdcc_pkg::result_t                    result
);

  logic [TIME_BITS-1:0] last_close_time;
  logic [TIME_BITS-1:0] press_start_time;
  logic                 was_down;
  logic                 long_reported;

  logic [TIME_BITS-1:0] since_close;
  logic [TIME_BITS-1:0] since_press;
  logic                 in_window;
  logic                 down;
  logic                 held_long;
  logic                 was_down_next;
  logic                 long_reported_next;
  logic                 start_press;
  bdcc_pkg::event_t     evt;

  assign since_close = now - last_close_time;
  assign since_press = now - press_start_time;
  assign in_window   = !(since_close > TIME_BITS'(hold_ms));
  assign down        = in_window || pin_level;
  assign held_long   = since_press > TIME_BITS'(long_press_ms);

  always_comb begin
    evt                = bdcc_pkg::EV_NONE;
    was_down_next      = was_down;
    long_reported_next = long_reported;
    start_press        = 1'b0;
    if (!was_down) begin
      if (down) begin
        start_press        = 1'b1;
        was_down_next      = 1'b1;
        long_reported_next = 1'b0;
      end
    end else if (!down) begin
      was_down_next = 1'b0;
      if (held_long) begin
        if (!long_reported) begin
          long_reported_next = 1'b1;
          evt                = bdcc_pkg::EV_LONG;
        end
      end else begin
        evt = bdcc_pkg::EV_CLICK;
      end
    end else if (held_long && !long_reported) begin
      long_reported_next = 1'b1;
      evt                = bdcc_pkg::EV_LONG;
    end
  end

  assign result.pressed = down;
  assign result.evt     = evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_close_time  <= '0;
      press_start_time <= '0;
      was_down         <= 1'b0;
      long_reported    <= 1'b0;
    end else if (step) begin
      // restart the window on a closure seen outside it
      if (!in_window && pin_level) begin
        last_close_time <= now;
      end
      if (start_press) begin
        press_start_time <= now;
      end
      was_down      <= was_down_next;
      long_reported <= long_reported_next;
    end
  end

endmodule

// File: sv/button_debounce_click_classifier.sv
// Button debouncer with click / long-press classification. Every input request
// carries one poll: the raw pin level and a free-running millisecond timestamp.
// Every poll yields exactly one result: the debounced level and an event code
// (none, click, long press). The button reads pressed while the time since the
// last closure seen outside the window is at most hold_ms; a press released
// within long_press_ms is a click, and holding past long_press_ms reports one
// long press. Timestamps are kept and subtracted modulo 2^TIME_BITS; all
// comparisons are strict greater-than. After reset the window is open against
// timestamp zero, so early polls read pressed. Rate: one poll per clock cycle
// while the result side keeps up. A poll passes through the input register,
// then one subtract-compare pass into the result register that also updates
// the state. The input side stalls only while a finished result waits.
// Configuration writes take effect at once and should be issued while idle.
module button_debounce_click_classifier #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [bdcc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [0] pin_level, [32:1] now_ms
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [bdcc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [0] pressed, [2:1] event_res
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bdcc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bdcc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // Configuration registers
  logic [bdcc_pkg::CFG_DATA_W-1:0] hold_ms;
  logic [bdcc_pkg::CFG_DATA_W-1:0] long_press_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms       <= bdcc_pkg::HOLD_MS_RESET;
      long_press_ms <= bdcc_pkg::LONG_PRESS_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bdcc_pkg::REG_HOLD_MS:       hold_ms       <= cfg_data;
        bdcc_pkg::REG_LONG_PRESS_MS: long_press_ms <= cfg_data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Input register
  logic                        in_valid;
  logic                        in_pin;
  logic [bdcc_pkg::NOW_W-1:0]  in_now;
  logic                        out_free;
  logic                        advance;
  logic                        s_fire;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_pin <= s_axis_tdata[0];
      in_now <= s_axis_tdata[bdcc_pkg::NOW_W:1];
    end
  end

  // Debounce and classify: state advances once per poll leaving the input register
  bdcc_pkg::result_t result;

  bdcc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .pin_level     (in_pin),
    .now           (TIME_BITS'(in_now)),
    .hold_ms       (hold_ms),
    .long_press_ms (long_press_ms),
    .result        (result)
  );

  // Result register: hold until taken
  bdcc_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_axis_tdata = {5'b0, out_res.evt, out_res.pressed};

endmodule

// File: sv/bdcc_checker.sv
module bdcc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bdcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // A click comes only with the debounced release
  a_click_released: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:1] == bdcc_pkg::EV_CLICK |-> !m_axis_tdata[0])
    else $error("click reported while pressed");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:1] != 2'd3)
    else $error("undefined event code");

  // Input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind button_debounce_click_classifier bdcc_checker u_bdcc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned HOLD_OFF_AT    = 250;   // result count that starts the long stall
  localparam int unsigned HOLD_OFF_LEN   = 80;    // cycles the result side holds off
  localparam int unsigned DRAIN_CYCLES   = 10;    // settle time after the last result

  // One poll as it travels in s_axis_tdata: pin level in bit 0, timestamp above it.
  typedef struct packed {
    logic [bdcc_pkg::NOW_W-1:0] now;
    logic                       pin;
  } poll_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [bdcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [bdcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [bdcc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [bdcc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor copy of the block: thresholds and classifier state.
  logic [bdcc_pkg::CFG_DATA_W-1:0]  hold_window;
  logic [bdcc_pkg::CFG_DATA_W-1:0]  long_threshold;
  logic [bdcc_pkg::NOW_W-1:0]       last_close_ms;
  logic [bdcc_pkg::NOW_W-1:0]       press_start_ms;
  logic                             was_pressed;
  logic                             long_flagged;

  poll_t                            poll_queue[$];        // polls waiting to be offered
  bdcc_pkg::result_t                expected_results[$];  // level + event per accepted poll

  logic [bdcc_pkg::NOW_W-1:0]       clock_ms;             // running timestamp for polls
  bit                               burst_mode;           // no idling on either side while set
  int unsigned                      send_gap;
  int unsigned                      recv_gap;
  int unsigned                      hold_off_left;
  bit                               held_off;
  int unsigned                      idle_cycles;
  int unsigned                      polls_accepted;
  int unsigned                      results_seen;
  int unsigned                      clicks_seen;
  int unsigned                      longs_seen;
  int unsigned                      reg_writes;
  int unsigned                      mismatches;

  button_debounce_click_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Debounce one poll and classify the debounced edge, updating the predictor state.
  // Time differences are taken at 32 bits so they wrap like the timestamps do.
  function automatic bdcc_pkg::result_t classify_poll(input logic pin,
                                                      input logic [bdcc_pkg::NOW_W-1:0] now);
    bdcc_pkg::result_t          res;
    logic                       down;
    logic [bdcc_pkg::NOW_W-1:0] since_close;
    logic [bdcc_pkg::NOW_W-1:0] held_for;
    since_close = now - last_close_ms;
    down = 1'b1;
    // Outside the window a closed pin restarts it; an open pin reads released.
    if (since_close > hold_window) begin
      if (pin) last_close_ms = now;
      else down = 1'b0;
    end
    held_for = now - press_start_ms;
    res.evt = bdcc_pkg::EV_NONE;
    if (!was_pressed) begin
      if (down) begin
        press_start_ms = now;
        was_pressed = 1'b1;
        long_flagged = 1'b0;
      end
    end else if (!down) begin
      was_pressed = 1'b0;
      // A release past the threshold reports the long press unless it already went out.
      if (held_for > long_threshold) begin
        if (!long_flagged) begin
          long_flagged = 1'b1;
          res.evt = bdcc_pkg::EV_LONG;
        end
      end else begin
        res.evt = bdcc_pkg::EV_CLICK;
      end
    end else if (held_for > long_threshold && !long_flagged) begin
      long_flagged = 1'b1;
      res.evt = bdcc_pkg::EV_LONG;
    end
    res.pressed = down;
    return res;
  endfunction

  // Mostly short gaps, some medium, a few long; none at all in burst mode.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Advance the timestamp on the scale of the current thresholds, with rare wild jumps.
  function automatic logic [bdcc_pkg::NOW_W-1:0] time_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, hold_window + 2);
    if (r < 85) return $urandom_range(0, long_threshold / 4 + 2);
    if (r < 97) return $urandom_range(0, long_threshold + hold_window + 4);
    return $urandom();
  endfunction

  task automatic queue_poll(input logic pin, input logic [bdcc_pkg::NOW_W-1:0] now);
    poll_t p;
    p.pin = pin;
    p.now = now;
    poll_queue.push_back(p);
  endtask

  // Alternate held and released stretches with contact bounce, plus some pure noise.
  task automatic queue_random_polls(input int unsigned count);
    int unsigned left;
    int unsigned run_len;
    int unsigned r;
    logic        held;
    logic        pin;
    left = count;
    held = 1'b0;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      run_len = held ? $urandom_range(1, 12) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < run_len && left > 0; i++) begin
        if (r < 10) begin
          pin = 1'($urandom_range(0, 1));
        end else begin
          pin = held;
          if ($urandom_range(0, 99) < 12) pin = !held;
        end
        clock_ms = clock_ms + time_step();
        queue_poll(pin, clock_ms);
        left--;
      end
      held = !held;
    end
  endtask

  // Sample at the falling edge so the check never races the clocked processes.
  task automatic wait_idle();
    do @(negedge clk);
    while (poll_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  // Write one register through the config channel; call only while the block is idle.
  task automatic write_reg(input logic [bdcc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdcc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      bdcc_pkg::REG_HOLD_MS:       hold_window = val;
      bdcc_pkg::REG_LONG_PRESS_MS: long_threshold = val;
      default: ;  // unknown index: drop the write
    endcase
  endtask

  // Driver: predict each accepted poll, then offer the next one after a random gap.
  always @(posedge clk) begin
    poll_t p;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(classify_poll(s_axis_tdata[0],
                                                 s_axis_tdata[bdcc_pkg::NOW_W:1]));
        polls_accepted++;
      end
      // Hold the current request until it is taken.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (poll_queue.size() != 0) begin
          p = poll_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(bdcc_pkg::IN_TDATA_W - bdcc_pkg::NOW_W - 1){1'b0}}, p};
          send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation, stall at random.
  always @(posedge clk) begin
    bdcc_pkg::result_t exp_res;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result pressed=%0d event=%0d", $time,
                   m_axis_tdata[0], m_axis_tdata[2:1]);
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.evt == bdcc_pkg::EV_CLICK) clicks_seen++;
          if (exp_res.evt == bdcc_pkg::EV_LONG) longs_seen++;
          if (m_axis_tdata[0] !== exp_res.pressed) begin
            mismatches++;
            $display("%0t: pressed mismatch, expected %0d actual %0d", $time,
                     exp_res.pressed, m_axis_tdata[0]);
          end
          if (m_axis_tdata[2:1] !== exp_res.evt) begin
            mismatches++;
            $display("%0t: event mismatch, expected %0d actual %0d", $time,
                     exp_res.evt, m_axis_tdata[2:1]);
          end
        end
      end
      // One long hold-off mid-run so the pipeline fills and backs up the input side.
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else if (!held_off && results_seen >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        hold_off_left = HOLD_OFF_LEN;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Watchdog: end the run when no channel has moved a request for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    hold_window    = bdcc_pkg::HOLD_MS_RESET;
    long_threshold = bdcc_pkg::LONG_PRESS_MS_RESET;
    last_close_ms  = '0;
    press_start_ms = '0;
    was_pressed    = 1'b0;
    long_flagged   = 1'b0;
    burst_mode     = 1'b0;
    send_gap = 0; recv_gap = 0; hold_off_left = 0; held_off = 1'b0; idle_cycles = 0;
    polls_accepted = 0; results_seen = 0; clicks_seen = 0; longs_seen = 0;
    reg_writes = 0; mismatches = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset thresholds. The window is open against timestamp zero right after reset,
    // so the first polls read pressed even with the pin open.
    @(negedge clk);
    queue_poll(1'b0, 32'd0);
    queue_poll(1'b0, 32'd50);         // still inside, boundary is strict
    queue_poll(1'b0, 32'd51);         // released: click
    queue_poll(1'b1, 32'd1000);       // press
    queue_poll(1'b1, 32'd1500);       // exactly at threshold: nothing yet
    queue_poll(1'b1, 32'd1501);       // long press while held
    queue_poll(1'b0, 32'd1600);       // release after report: nothing
    queue_poll(1'b1, 32'd2000);
    queue_poll(1'b0, 32'd2600);       // release past threshold reports the long press
    queue_poll(1'b1, 32'hFFFF_FFF0);  // timestamp about to wrap
    queue_poll(1'b0, 32'hFFFF_FFFF);
    queue_poll(1'b0, 32'h0000_0050);  // difference taken across the wrap
    queue_poll(1'b1, 32'd5000);       // contact bounce inside the window
    queue_poll(1'b0, 32'd5010);
    queue_poll(1'b1, 32'd5020);
    queue_poll(1'b0, 32'd5071);
    wait_idle();

    // Zero thresholds: any elapsed time counts.
    write_reg(bdcc_pkg::REG_HOLD_MS, 16'd0);
    write_reg(bdcc_pkg::REG_LONG_PRESS_MS, 16'd0);
    @(negedge clk);
    queue_poll(1'b1, 32'd7000);
    queue_poll(1'b1, 32'd7000);
    queue_poll(1'b1, 32'd7001);
    queue_poll(1'b0, 32'd7001);
    queue_poll(1'b0, 32'd7002);
    wait_idle();

    // Writes to unknown indexes must leave both thresholds alone.
    write_reg(8'hFF, 16'hFFFF);
    write_reg(8'h02, 16'hA5A5);
    write_reg(bdcc_pkg::REG_LONG_PRESS_MS, 16'hFFFF);
    @(negedge clk);
    queue_poll(1'b1, 32'd8000);
    queue_poll(1'b0, 32'd8001);
    wait_idle();

    // Full-scale thresholds.
    write_reg(bdcc_pkg::REG_HOLD_MS, 16'hFFFF);
    @(negedge clk);
    queue_poll(1'b1, 32'h0010_0000);
    queue_poll(1'b0, 32'h0010_FFFF);
    queue_poll(1'b0, 32'h0011_0000);
    wait_idle();

    // Random phases, each with its own threshold setting; drain between them.
    write_reg(bdcc_pkg::REG_HOLD_MS, bdcc_pkg::HOLD_MS_RESET);
    write_reg(bdcc_pkg::REG_LONG_PRESS_MS, bdcc_pkg::LONG_PRESS_MS_RESET);
    @(negedge clk);
    clock_ms = 32'd20000;
    queue_random_polls(100);
    wait_idle();

    write_reg(bdcc_pkg::REG_HOLD_MS, 16'd3);
    write_reg(bdcc_pkg::REG_LONG_PRESS_MS, 16'd20);
    @(negedge clk);
    burst_mode = 1'b1;
    clock_ms = 32'hFFFF_FE00;  // run across the wrap
    queue_random_polls(100);
    wait_idle();
    burst_mode = 1'b0;

    write_reg(bdcc_pkg::REG_HOLD_MS, bdcc_pkg::CFG_DATA_W'($urandom_range(0, 300)));
    write_reg(bdcc_pkg::REG_LONG_PRESS_MS, bdcc_pkg::CFG_DATA_W'($urandom_range(0, 2000)));
    @(negedge clk);
    queue_random_polls(100);
    wait_idle();

    write_reg(bdcc_pkg::REG_HOLD_MS, 16'hFFFF);
    write_reg(bdcc_pkg::REG_LONG_PRESS_MS, 16'hFFFF);
    @(negedge clk);
    queue_random_polls(50);
    wait_idle();

    write_reg(bdcc_pkg::REG_HOLD_MS, 16'd0);
    write_reg(bdcc_pkg::REG_LONG_PRESS_MS, 16'd0);
    @(negedge clk);
    queue_random_polls(50);
    wait_idle();

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("covered %0d polls and %0d results, %0d clicks, %0d long presses",
             polls_accepted, results_seen, clicks_seen, longs_seen);
    $display("over %0d register writes incl. zero, full-scale and unknown-index settings",
             reg_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
